// ----- sv/tlptm_pkg.sv -----
// Shared types and constants for the two-level page table mapper.
// Depends on nothing; used by the mapper core.
package tlptm_pkg;

	// Page geometry: 4 KiB pages, 1024 entries of 32 bits per page
	localparam int ENTRIES_PER_PAGE = 1024;
	localparam int IDX_W            = 10;
	localparam int OFS_W            = 12;
	localparam int FRAME_W          = 32 - OFS_W;
	localparam int POOL_PAGES_DEF   = 64;

	// Entry flag bits and masks
	localparam logic [31:0] ENTRY_PRESENT  = 32'h0000_0001;
	localparam logic [31:0] ENTRY_WRITABLE = 32'h0000_0002;
	localparam logic [11:0] FLAG_MASK      = 12'hFFF;

	// Result status codes
	localparam logic ST_MAPPED  = 1'b0;
	localparam logic ST_NO_PAGE = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_SWEEP,
		S_COMMIT
	} tlptm_state_t;

endpackage

// ----- sv/two_level_page_table_mapper_core.sv -----
// Two-level page table mapper: directory RAM, table RAM and the map sequencer.
// Depends on tlptm_pkg and tlptm_ram.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one map request: phys_addr,
//    virt_addr (31:22 directory index, 21:12 table index) and page_flags.
//  - Output channel (out_valid/out_ready) returns one result per request:
//    status, table_allocated, directory_entry and table_entry.
//  - cfg_wr_en/cfg_wr_data write pool_base_address; write it only while idle.
//  - A request whose directory entry is present goes through the directory RAM's
//    registered read, then a commit step that writes the table entry and loads
//    the output register. The sequencer then returns to idle, and only there
//    does it take the next transfer.
//  - A request that allocates a new table first clears the new table page,
//    entry by entry, through the single table RAM write port.
//  - After reset the directory RAM is cleared one entry per cycle; in_ready
//    stays low meanwhile, configuration writes still land.
//  - A finished result sits in an output register; the next request may be
//    taken while it waits. If the receiver stalls, the following request holds
//    in its commit step until the output register frees.
//  - When the pool is used up a request needing a new table returns status 1
//    and changes nothing.
module two_level_page_table_mapper_core
	import tlptm_pkg::*;
#(
	parameter int POOL_PAGES = POOL_PAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] phys_addr,
	input  logic [31:0] virt_addr,
	input  logic [11:0] page_flags,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic        table_allocated,
	output logic [31:0] directory_entry,
	output logic [31:0] table_entry
);

	localparam int UW        = $clog2(POOL_PAGES + 1);
	localparam int PG_W      = $clog2(POOL_PAGES);
	localparam int TBL_DEPTH = (POOL_PAGES - 1) * ENTRIES_PER_PAGE;
	localparam int TA_W      = PG_W + IDX_W;

	tlptm_state_t state_q, state_d;

	logic [IDX_W-1:0]   cnt_q;
	logic [UW-1:0]      pages_used_q;
	logic [31:0]        pool_q;
	logic [31:0]        phys_q;
	logic [31:0]        virt_q;
	logic [11:0]        flags_q;
	logic [31:0]        dentry_q;
	logic               alloc_q;
	logic               fail_q;
	logic [PG_W-1:0]    page_q;

	logic               out_valid_q;
	logic               status_q;
	logic               alloc_out_q;
	logic [31:0]        dentry_out_q;
	logic [31:0]        tentry_out_q;

	// RAM ports
	logic               dir_we;
	logic [IDX_W-1:0]   dir_waddr;
	logic [31:0]        dir_wdata;
	logic               dir_re;
	logic [31:0]        dir_rdata;
	logic               tbl_we;
	logic [TA_W-1:0]    tbl_waddr;
	logic [31:0]        tbl_wdata;

	// sequencer controls
	logic               accept;
	logic               slot_free;
	logic               do_lookup;
	logic               do_commit;
	logic               cnt_last;
	logic               entry_present;
	logic               pool_full;
	logic [FRAME_W-1:0] new_frame;
	logic [FRAME_W-1:0] page_calc;
	logic               page_hit;
	logic [31:0]        tentry;

	assign accept        = in_valid && in_ready;
	assign slot_free     = !out_valid_q || out_ready;
	assign cnt_last      = (cnt_q == {IDX_W{1'b1}});
	assign entry_present = dir_rdata[0];
	assign pool_full     = (pages_used_q >= UW'(POOL_PAGES));
	assign new_frame     = pool_q[31:OFS_W] + FRAME_W'(pages_used_q);
	assign page_calc     = dentry_q[31:OFS_W] - pool_q[31:OFS_W];
	assign page_hit      = (page_calc != '0) && (page_calc < FRAME_W'(pages_used_q))
	                       && (page_calc < FRAME_W'(POOL_PAGES));
	assign tentry        = phys_q | {20'b0, flags_q & FLAG_MASK} | ENTRY_PRESENT;

	// Next state and RAM port control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		do_lookup = 1'b0;
		do_commit = 1'b0;
		dir_we    = 1'b0;
		dir_waddr = virt_q[31:22];
		dir_wdata = dentry_q;
		dir_re    = 1'b0;
		tbl_we    = 1'b0;
		tbl_waddr = {PG_W'(page_calc - FRAME_W'(1)), virt_q[21:12]};
		tbl_wdata = tentry;
		unique case (state_q)
			S_CLEAR: begin
				dir_we    = 1'b1;
				dir_waddr = cnt_q;
				dir_wdata = '0;
				if (cnt_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				dir_re   = in_valid;
				if (in_valid) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				do_lookup = 1'b1;
				if (!entry_present && !pool_full) state_d = S_SWEEP;
				else state_d = S_COMMIT;
			end
			S_SWEEP: begin
				tbl_we    = 1'b1;
				tbl_waddr = {page_q, cnt_q};
				tbl_wdata = '0;
				if (cnt_last) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (slot_free) begin
					do_commit = 1'b1;
					dir_we    = alloc_q;
					tbl_we    = !fail_q && page_hit;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: sweep counter, pool allocator, pool base, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			pages_used_q <= UW'(1);
			pool_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_CLEAR || state_q == S_SWEEP) cnt_q <= cnt_q + IDX_W'(1);
			else cnt_q <= '0;
			if (do_lookup && !entry_present && !pool_full) begin
				pages_used_q <= pages_used_q + UW'(1);
			end
			if (cfg_wr_en) pool_q <= cfg_wr_data;
			if (do_commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			phys_q  <= phys_addr;
			virt_q  <= virt_addr;
			flags_q <= page_flags;
		end
		if (do_lookup) begin
			alloc_q <= !entry_present && !pool_full;
			fail_q  <= !entry_present && pool_full;
			page_q  <= PG_W'(pages_used_q - UW'(1));
			if (!entry_present && !pool_full) begin
				dentry_q <= {new_frame, 12'b0} | ENTRY_PRESENT | ENTRY_WRITABLE;
			end else begin
				dentry_q <= dir_rdata;
			end
		end
		if (do_commit) begin
			status_q     <= fail_q ? ST_NO_PAGE : ST_MAPPED;
			alloc_out_q  <= alloc_q;
			dentry_out_q <= dentry_q;
			tentry_out_q <= fail_q ? 32'b0 : tentry;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign table_allocated = alloc_out_q;
	assign directory_entry = dentry_out_q;
	assign table_entry     = tentry_out_q;

	// Page directory
	tlptm_ram #(
		.WIDTH (32),
		.DEPTH (ENTRIES_PER_PAGE),
		.ADDR_W(IDX_W)
	) u_dir_ram (
		.clk    (clk),
		.wr_en  (dir_we),
		.wr_addr(dir_waddr),
		.wr_data(dir_wdata),
		.rd_en  (dir_re),
		.rd_addr(virt_addr[31:22]),
		.rd_data(dir_rdata)
	);

	// Page tables, one page per allocated pool page after the directory
	tlptm_ram #(
		.WIDTH (32),
		.DEPTH (TBL_DEPTH),
		.ADDR_W(TA_W)
	) u_tbl_ram (
		.clk    (clk),
		.wr_en  (tbl_we),
		.wr_addr(tbl_waddr),
		.wr_data(tbl_wdata),
		.rd_en  (1'b0),
		.rd_addr('0),
		.rd_data()
	);

	// Allocator never passes the pool size
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pages_used_q <= UW'(POOL_PAGES))
		else $error("pages_used exceeds pool size");

	// Allocator only ever advances by one page
	a_pool_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pages_used_q) |-> pages_used_q == $past(pages_used_q) + UW'(1))
		else $error("pages_used moved by other than one");

	// A refused request reports no table and an empty entry
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NO_PAGE |-> !table_allocated && table_entry == 32'b0)
		else $error("failed result carries data");

	// A mapped request links a present table and a present entry
	a_map_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_MAPPED |-> table_entry[0] && directory_entry[0])
		else $error("mapped result not present");

	// A fresh table is linked read-write
	a_alloc_rw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_allocated |-> directory_entry[1:0] == 2'b11)
		else $error("new directory entry lacks present or read-write");

endmodule

// ----- sv/tlptm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tlptm_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
